FILE: rtl/two_wire_sensor_measure_master_macros.svh
// assertion macros used by the checker file
`ifndef TWO_WIRE_SENSOR_MEASURE_MASTER_MACROS_SVH
`define TWO_WIRE_SENSOR_MEASURE_MASTER_MACROS_SVH

// same-cycle implication, disabled while reset is held
`define TWS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("tws check failed");

// next-cycle implication, disabled while reset is held
`define TWS_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("tws check failed");

`endif

FILE: rtl/tws_pkg.sv
`default_nettype none
package tws_pkg;

    // command bytes
    localparam logic [7:0] CMD_TEMP = 8'h03;
    localparam logic [7:0] CMD_HUMI = 8'h05;

    // configuration register indexes and reset values
    localparam int unsigned CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_HALF_PERIOD = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT     = 1'b1;
    localparam logic [7:0]  HALF_PERIOD_RST = 8'd4;
    localparam logic [31:0] TIMEOUT_RST     = 32'hFFFF_FFFF;

    // sequencer phase codes
    localparam logic [3:0] PH_IDLE    = 4'd0;
    localparam logic [3:0] PH_RST_HI  = 4'd1;
    localparam logic [3:0] PH_RST_LO  = 4'd2;
    localparam logic [3:0] PH_TS      = 4'd3;
    localparam logic [3:0] PH_WR_LO   = 4'd4;
    localparam logic [3:0] PH_WR_HI   = 4'd5;
    localparam logic [3:0] PH_ACK_LO  = 4'd6;
    localparam logic [3:0] PH_ACK_HI  = 4'd7;
    localparam logic [3:0] PH_WAIT    = 4'd8;
    localparam logic [3:0] PH_RD_LO   = 4'd9;
    localparam logic [3:0] PH_RD_HI   = 4'd10;
    localparam logic [3:0] PH_ACKR_LO = 4'd11;
    localparam logic [3:0] PH_ACKR_HI = 4'd12;
    localparam logic [3:0] PH_DONE    = 4'd13;

    typedef struct packed {
        logic start_req;
        logic func;
        logic reset_first;
        logic data_in;
    } t_item;

    typedef struct packed {
        logic        sck;
        logic        data_pull_low;
        logic        busy_res;
        logic        done_res;
        logic        nack_error;
        logic        timeout_error;
        logic [15:0] measurement;
        logic [7:0]  checksum;
    } t_result;

    typedef struct packed {
        logic [7:0]  half_period_ticks;
        logic [31:0] ready_timeout_ticks;
    } t_cfg;

endpackage
`default_nettype wire

FILE: rtl/tws_step.sv
`default_nettype none
module tws_step (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire tws_pkg::t_item  i_item,
    input  wire tws_pkg::t_cfg   i_cfg,
    output tws_pkg::t_result     o_res
);
    import tws_pkg::*;

    logic [3:0]  r_phase, n_phase;
    logic [7:0]  r_td, n_td;
    logic [3:0]  r_bit, n_bit;
    logic [1:0]  r_byte, n_byte;
    logic [7:0]  r_shift, n_shift;
    logic [31:0] r_wait, n_wait;
    logic [15:0] r_result, n_result;
    logic [7:0]  r_chk, n_chk;
    logic [1:0]  r_err, n_err;
    logic [7:0]  r_cmd, n_cmd;

    logic [7:0]  w_len;
    logic [31:0] w_limit;
    logic        w_end;
    logic        w_wait_end;
    logic        w_wr_pull;
    logic        w_slot;
    logic        w_accept;

    // zero in a length register acts as one
    assign w_len      = (i_cfg.half_period_ticks == 8'd0) ? 8'd1 : i_cfg.half_period_ticks;
    assign w_limit    = (i_cfg.ready_timeout_ticks == 32'd0) ? 32'd1
                                                              : i_cfg.ready_timeout_ticks;
    assign w_end      = ({1'b0, r_td} + 9'd1) >= {1'b0, w_len};
    assign w_wait_end = ({1'b0, r_wait} + 33'd1) >= {1'b0, w_limit};
    // command bit msb first, a one releases the line
    assign w_wr_pull  = ~r_cmd[3'd7 - r_bit[2:0]];

    // one tick of the bus sequencer
    always_comb begin
        n_phase  = r_phase;
        n_td     = r_td;
        n_bit    = r_bit;
        n_byte   = r_byte;
        n_shift  = r_shift;
        n_wait   = r_wait;
        n_result = r_result;
        n_chk    = r_chk;
        n_err    = r_err;
        n_cmd    = r_cmd;
        o_res    = '0;
        o_res.busy_res = 1'b1;
        w_slot   = 1'b1;
        w_accept = 1'b0;

        unique case (r_phase)
            PH_IDLE: begin
                o_res.busy_res = 1'b0;
                w_slot   = 1'b0;
                n_td     = 8'd0;
                w_accept = 1'b1;
            end
            PH_DONE: begin
                o_res.busy_res      = 1'b0;
                o_res.done_res      = 1'b1;
                o_res.measurement   = r_result;
                o_res.checksum      = r_chk;
                o_res.nack_error    = r_err[0];
                o_res.timeout_error = r_err[1];
                w_slot   = 1'b0;
                n_phase  = PH_IDLE;
                n_td     = 8'd0;
                w_accept = 1'b1;
            end
            PH_RST_HI: begin
                o_res.sck = 1'b1;
                if (w_end) n_phase = PH_RST_LO;
            end
            PH_RST_LO: begin
                if (w_end) begin
                    if (r_bit >= 4'd8) begin
                        n_bit   = 4'd0;
                        n_phase = PH_TS;
                    end else begin
                        n_bit   = r_bit + 4'd1;
                        n_phase = PH_RST_HI;
                    end
                end
            end
            PH_TS: begin
                o_res.sck           = (r_bit != 4'd2);
                o_res.data_pull_low = (r_bit >= 4'd1) && (r_bit <= 4'd3);
                if (w_end) begin
                    if (r_bit >= 4'd4) begin
                        n_bit   = 4'd0;
                        n_phase = PH_WR_LO;
                    end else begin
                        n_bit = r_bit + 4'd1;
                    end
                end
            end
            PH_WR_LO: begin
                o_res.data_pull_low = w_wr_pull;
                if (w_end) n_phase = PH_WR_HI;
            end
            PH_WR_HI: begin
                o_res.sck           = 1'b1;
                o_res.data_pull_low = w_wr_pull;
                if (w_end) begin
                    if (r_bit >= 4'd7) begin
                        n_bit   = 4'd0;
                        n_phase = PH_ACK_LO;
                    end else begin
                        n_bit   = r_bit + 4'd1;
                        n_phase = PH_WR_LO;
                    end
                end
            end
            PH_ACK_LO: begin
                if (w_end) n_phase = PH_ACK_HI;
            end
            PH_ACK_HI: begin
                o_res.sck = 1'b1;
                if (w_end) begin
                    if (i_item.data_in) n_err[0] = 1'b1;
                    n_wait  = 32'd0;
                    n_phase = PH_WAIT;
                end
            end
            PH_WAIT: begin
                w_slot = 1'b0;
                n_td   = 8'd0;
                if (!i_item.data_in || w_wait_end) begin
                    if (i_item.data_in) n_err[1] = 1'b1;
                    n_bit   = 4'd0;
                    n_byte  = 2'd0;
                    n_shift = 8'd0;
                    n_phase = PH_RD_LO;
                end else begin
                    n_wait = r_wait + 32'd1;
                end
            end
            PH_RD_LO: begin
                if (w_end) n_phase = PH_RD_HI;
            end
            PH_RD_HI: begin
                o_res.sck = 1'b1;
                if (w_end) begin
                    n_shift = {r_shift[6:0], i_item.data_in};
                    if (r_bit >= 4'd7) begin
                        n_bit   = 4'd0;
                        n_phase = PH_ACKR_LO;
                    end else begin
                        n_bit   = r_bit + 4'd1;
                        n_phase = PH_RD_LO;
                    end
                end
            end
            PH_ACKR_LO: begin
                o_res.data_pull_low = (r_byte < 2'd2);
                if (w_end) n_phase = PH_ACKR_HI;
            end
            PH_ACKR_HI: begin
                o_res.sck           = 1'b1;
                o_res.data_pull_low = (r_byte < 2'd2);
                if (w_end) begin
                    if (r_byte == 2'd0) n_result = {r_shift, 8'h00};
                    else if (r_byte == 2'd1) n_result = {r_result[15:8], r_shift};
                    else n_chk = r_shift;
                    if (r_byte >= 2'd2) begin
                        n_phase = PH_DONE;
                    end else begin
                        n_byte  = r_byte + 2'd1;
                        n_shift = 8'd0;
                        n_phase = PH_RD_LO;
                    end
                end
            end
            default: begin
                // unused phase codes fall back to idle
                o_res.busy_res = 1'b0;
                w_slot  = 1'b0;
                n_td    = 8'd0;
                n_phase = PH_IDLE;
            end
        endcase

        // half-period slot timer
        if (w_slot) n_td = w_end ? 8'd0 : r_td + 8'd1;

        // start of a new transaction
        if (w_accept && i_item.start_req) begin
            n_cmd   = i_item.func ? CMD_HUMI : CMD_TEMP;
            n_err   = 2'd0;
            n_td    = 8'd0;
            n_bit   = 4'd0;
            n_byte  = 2'd0;
            n_shift = 8'd0;
            n_wait  = 32'd0;
            n_phase = i_item.reset_first ? PH_RST_HI : PH_TS;
        end
    end

    // sequencer state, advanced once per item
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_IDLE;
            r_td     <= 8'd0;
            r_bit    <= 4'd0;
            r_byte   <= 2'd0;
            r_shift  <= 8'd0;
            r_wait   <= 32'd0;
            r_result <= 16'd0;
            r_chk    <= 8'd0;
            r_err    <= 2'd0;
            r_cmd    <= 8'd0;
        end else if (i_en) begin
            r_phase  <= n_phase;
            r_td     <= n_td;
            r_bit    <= n_bit;
            r_byte   <= n_byte;
            r_shift  <= n_shift;
            r_wait   <= n_wait;
            r_result <= n_result;
            r_chk    <= n_chk;
            r_err    <= n_err;
            r_cmd    <= n_cmd;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/two_wire_sensor_measure_master.sv
// Two-wire humidity/temperature sensor bus master. Each input item is one bus
// tick and yields exactly one result item carrying the line levels and status
// for that tick; done_res marks the tick that carries measurement, checksum
// and the nack and timeout flags. One item is accepted every cycle while results
// are taken downstream; its result passes through the input register, the
// combinational sequencer step and the result register behind it. While a
// result waits downstream one more item can be taken into the input register;
// after that ready stays low until the result is taken. Configuration (half
// period, ready timeout) is written through the plain write port; the user
// writes it only while the block is idle, the block itself does not enforce it.
`default_nettype none
module two_wire_sensor_measure_master (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    // configuration write port
    input  wire logic                          i_cfg_we,
    input  wire logic [tws_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire logic [31:0]                   i_cfg_data,
    // input item channel
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic                          i_start_req,
    input  wire logic                          i_func,
    input  wire logic                          i_reset_first,
    input  wire logic                          i_data_in,
    // result item channel
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic                               o_sck,
    output logic                               o_data_pull_low,
    output logic                               o_busy_res,
    output logic                               o_done_res,
    output logic                               o_nack_error,
    output logic                               o_timeout_error,
    output logic [15:0]                        o_measurement,
    output logic [7:0]                         o_checksum
);
    import tws_pkg::*;

    t_cfg    r_cfg;
    logic    r_in_valid;
    t_item   r_in;
    logic    r_out_valid;
    t_result r_out;
    t_result w_res;
    logic    w_advance;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.half_period_ticks   <= HALF_PERIOD_RST;
            r_cfg.ready_timeout_ticks <= TIMEOUT_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_HALF_PERIOD: r_cfg.half_period_ticks   <= i_cfg_data[7:0];
                REG_TIMEOUT:     r_cfg.ready_timeout_ticks <= i_cfg_data;
            endcase
        end
    end

    // handshake: the step runs when an item is held and the result slot frees
    assign w_advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready   = !r_in_valid || w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_ready) begin
            r_in_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= '{start_req: i_start_req, func: i_func,
                      reset_first: i_reset_first, data_in: i_data_in};
        end
    end

    tws_step u_step (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_advance),
        .i_item  (r_in),
        .i_cfg   (r_cfg),
        .o_res   (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out <= w_res;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_sck           = r_out.sck;
    assign o_data_pull_low = r_out.data_pull_low;
    assign o_busy_res      = r_out.busy_res;
    assign o_done_res      = r_out.done_res;
    assign o_nack_error    = r_out.nack_error;
    assign o_timeout_error = r_out.timeout_error;
    assign o_measurement   = r_out.measurement;
    assign o_checksum      = r_out.checksum;

endmodule
`default_nettype wire

FILE: rtl/tws_checker.sv
`default_nettype none
`include "two_wire_sensor_measure_master_macros.svh"
module tws_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_o_valid,
    input wire logic        i_i_ready,
    input wire logic        i_sck,
    input wire logic        i_data_pull_low,
    input wire logic        i_busy_res,
    input wire logic        i_done_res,
    input wire logic        i_nack_error,
    input wire logic        i_timeout_error,
    input wire logic [15:0] i_measurement,
    input wire logic [7:0]  i_checksum
);
    // a done item is never marked busy
    `TWS_ASSERT_IMP(a_done_not_busy, i_clk, i_rst_n, i_o_valid && i_done_res, !i_busy_res)

    // result fields stay zero outside the done item
    `TWS_ASSERT_IMP(a_fields_zero, i_clk, i_rst_n, i_o_valid && !i_done_res, (i_measurement == 16'd0) && (i_checksum == 8'd0) && !i_nack_error && !i_timeout_error)

    // idle items leave the bus released with the clock low
    `TWS_ASSERT_IMP(a_idle_lines, i_clk, i_rst_n, i_o_valid && !i_busy_res && !i_done_res, !i_sck && !i_data_pull_low)

    // a stalled item holds
    `TWS_ASSERT_NXT(a_stall_hold, i_clk, i_rst_n, i_o_valid && !i_i_ready, i_o_valid && $stable(i_measurement) && $stable(i_sck) && $stable(i_done_res))

endmodule

bind two_wire_sensor_measure_master tws_checker u_tws_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_o_valid       (o_valid),
    .i_i_ready       (i_ready),
    .i_sck           (o_sck),
    .i_data_pull_low (o_data_pull_low),
    .i_busy_res      (o_busy_res),
    .i_done_res      (o_done_res),
    .i_nack_error    (o_nack_error),
    .i_timeout_error (o_timeout_error),
    .i_measurement   (o_measurement),
    .i_checksum      (o_checksum)
);
`default_nettype wire

FILE: tb/sv/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import tws_pkg::*;

    localparam int CLK_HALF_NS = 4;
    localparam int RESET_CYCLES = 11;
    localparam longint WATCHDOG_NS = 64'd16_000_000;
    localparam int TAIL_CYCLES = 20;
    localparam int DIR_COUNT = 9;
    localparam int RAND_ITEMS = 100;

    // one directed measurement: settings, sensor behaviour and, where obvious, the outcome
    typedef struct packed {
        logic [7:0]  half;
        logic [31:0] limit;
        logic        func;
        logic        rst_first;
        logic [3:0]  idle_n;
        logic        chain;
        logic        ack_hi;
        logic [7:0]  hold;
        logic [7:0]  b0;
        logic [7:0]  b1;
        logic [7:0]  b2;
        logic        known;
        logic [15:0] meas;
        logic [7:0]  chk;
        logic        nack;
        logic        tmo;
    } t_dir_row;

    localparam t_dir_row DIR_ROWS [0:DIR_COUNT-1] = '{
        '{HALF_PERIOD_RST, TIMEOUT_RST, 1'b0, 1'b0, 4'd3, 1'b0, 1'b0, 8'd0,
          8'h00, 8'h00, 8'h00, 1'b1, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{8'd0, TIMEOUT_RST, 1'b1, 1'b1, 4'd0, 1'b0, 1'b0, 8'd3,
          8'hFF, 8'hFF, 8'hFF, 1'b1, 16'hFFFF, 8'hFF, 1'b0, 1'b0},
        '{8'd0, TIMEOUT_RST, 1'b0, 1'b1, 4'd1, 1'b1, 1'b1, 8'd2,
          8'hA5, 8'h5A, 8'hC3, 1'b1, 16'hA55A, 8'hC3, 1'b1, 1'b0},
        '{8'd1, 32'd0, 1'b1, 1'b0, 4'd0, 1'b0, 1'b0, 8'd5,
          8'h12, 8'h34, 8'h56, 1'b1, 16'h1234, 8'h56, 1'b0, 1'b1},
        '{8'd1, 32'd0, 1'b0, 1'b0, 4'd0, 1'b1, 1'b0, 8'd0,
          8'h80, 8'h01, 8'h7F, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{8'd2, 32'd4, 1'b1, 1'b1, 4'd2, 1'b0, 1'b0, 8'd3,
          8'h0F, 8'hF0, 8'h3C, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b0},
        '{8'd1, 32'd2, 1'b0, 1'b0, 4'd1, 1'b0, 1'b1, 8'd9,
          8'h00, 8'hFF, 8'h00, 1'b1, 16'h00FF, 8'h00, 1'b1, 1'b1},
        '{8'd1, TIMEOUT_RST, 1'b1, 1'b1, 4'd0, 1'b0, 1'b0, 8'd20,
          8'hAA, 8'h55, 8'hFF, 1'b1, 16'hAA55, 8'hFF, 1'b0, 1'b0},
        '{8'd1, TIMEOUT_RST, 1'b1, 1'b0, 4'd0, 1'b0, 1'b1, 8'd1,
          8'h3C, 8'hC3, 8'h99, 1'b0, 16'h0000, 8'h00, 1'b0, 1'b0}
    };

    // dut connections
    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = REG_HALF_PERIOD;
    logic [31:0]          i_cfg_data = 32'd0;
    logic                 in_valid = 1'b0;
    logic                 o_ready;
    logic                 i_start_req = 1'b0;
    logic                 i_func = 1'b0;
    logic                 i_reset_first = 1'b0;
    logic                 i_data_in = 1'b1;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    logic                 o_sck;
    logic                 o_data_pull_low;
    logic                 o_busy_res;
    logic                 o_done_res;
    logic                 o_nack_error;
    logic                 o_timeout_error;
    logic [15:0]          o_measurement;
    logic [7:0]           o_checksum;

    // bus master mirror state and its copy of the registers
    logic [3:0]  bus_phase = PH_IDLE;
    logic [7:0]  slot_cnt = 8'd0;
    logic [3:0]  bit_idx = 4'd0;
    logic [1:0]  byte_idx = 2'd0;
    logic [7:0]  rx_shift = 8'd0;
    logic [31:0] wait_cnt = 32'd0;
    logic [15:0] meas_word = 16'd0;
    logic [7:0]  chk_byte = 8'd0;
    logic [1:0]  err_flags = 2'd0;
    logic [7:0]  cmd_byte = 8'd0;
    logic [7:0]  cfg_half = HALF_PERIOD_RST;
    logic [31:0] cfg_limit = TIMEOUT_RST;

    // sensor behaviour planned for the current measurement
    logic       plan_func;
    logic       plan_rst;
    logic       plan_nack;
    logic       plan_noise;
    int         plan_hold;
    int         hold_left;
    logic [7:0] plan_bytes [0:2];

    // typed-in outcome of a directed measurement, armed once its start is sent
    logic    want_known = 1'b0;
    t_result want_res;
    logic    pin_known = 1'b0;
    t_result pin_res;

    t_result bus_tick_q [$];
    int      items_sent = 0;
    int      fail_cnt = 0;
    int      gap_pct = 19;
    int      stall_pct = 57;

    two_wire_sensor_measure_master uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_idx       (i_cfg_idx),
        .i_cfg_data      (i_cfg_data),
        .i_valid         (in_valid),
        .o_ready         (o_ready),
        .i_start_req     (i_start_req),
        .i_func          (i_func),
        .i_reset_first   (i_reset_first),
        .i_data_in       (i_data_in),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_sck           (o_sck),
        .o_data_pull_low (o_data_pull_low),
        .o_busy_res      (o_busy_res),
        .o_done_res      (o_done_res),
        .o_nack_error    (o_nack_error),
        .o_timeout_error (o_timeout_error),
        .o_measurement   (o_measurement),
        .o_checksum      (o_checksum)
    );

    // clock
    always begin
        #CLK_HALF_NS i_clk = 1'b1;
        #CLK_HALF_NS i_clk = 1'b0;
    end

    // a start request only counts in idle or in the done tick
    task automatic take_start(input t_item it);
        if (it.start_req) begin
            cmd_byte = it.func ? CMD_HUMI : CMD_TEMP;
            err_flags = 2'd0;
            slot_cnt = 8'd0;
            bit_idx = 4'd0;
            byte_idx = 2'd0;
            rx_shift = 8'd0;
            wait_cnt = 32'd0;
            bus_phase = it.reset_first ? PH_RST_HI : PH_TS;
        end
    endtask

    // one bus tick of the master: line levels come from the state before the tick
    task automatic bus_master_step(input t_item it, output t_result r);
        logic [31:0] len;
        logic [31:0] lim;
        logic        slot_end;
        logic        in_slot;
        r = '0;
        r.busy_res = 1'b1;
        len = (cfg_half == 8'd0) ? 32'd1 : {24'd0, cfg_half};
        lim = (cfg_limit == 32'd0) ? 32'd1 : cfg_limit;
        slot_end = ({24'd0, slot_cnt} + 32'd1) >= len;
        in_slot = 1'b1;
        case (bus_phase)
            PH_IDLE: begin
                r.busy_res = 1'b0;
                in_slot = 1'b0;
                slot_cnt = 8'd0;
                take_start(it);
            end
            PH_DONE: begin
                r.busy_res = 1'b0;
                r.done_res = 1'b1;
                r.measurement = meas_word;
                r.checksum = chk_byte;
                r.nack_error = err_flags[0];
                r.timeout_error = err_flags[1];
                in_slot = 1'b0;
                bus_phase = PH_IDLE;
                slot_cnt = 8'd0;
                take_start(it);
            end
            PH_RST_HI: begin
                r.sck = 1'b1;
                if (slot_end) bus_phase = PH_RST_LO;
            end
            PH_RST_LO: begin
                if (slot_end) begin
                    if (bit_idx >= 4'd8) begin
                        bit_idx = 4'd0;
                        bus_phase = PH_TS;
                    end else begin
                        bit_idx = bit_idx + 4'd1;
                        bus_phase = PH_RST_HI;
                    end
                end
            end
            PH_TS: begin
                r.sck = (bit_idx != 4'd2);
                r.data_pull_low = (bit_idx >= 4'd1) && (bit_idx <= 4'd3);
                if (slot_end) begin
                    if (bit_idx >= 4'd4) begin
                        bit_idx = 4'd0;
                        bus_phase = PH_WR_LO;
                    end else begin
                        bit_idx = bit_idx + 4'd1;
                    end
                end
            end
            PH_WR_LO: begin
                r.data_pull_low = ~cmd_byte[3'd7 - bit_idx[2:0]];
                if (slot_end) bus_phase = PH_WR_HI;
            end
            PH_WR_HI: begin
                r.sck = 1'b1;
                r.data_pull_low = ~cmd_byte[3'd7 - bit_idx[2:0]];
                if (slot_end) begin
                    if (bit_idx >= 4'd7) begin
                        bit_idx = 4'd0;
                        bus_phase = PH_ACK_LO;
                    end else begin
                        bit_idx = bit_idx + 4'd1;
                        bus_phase = PH_WR_LO;
                    end
                end
            end
            PH_ACK_LO: begin
                if (slot_end) bus_phase = PH_ACK_HI;
            end
            PH_ACK_HI: begin
                r.sck = 1'b1;
                if (slot_end) begin
                    if (it.data_in) err_flags[0] = 1'b1;
                    wait_cnt = 32'd0;
                    bus_phase = PH_WAIT;
                end
            end
            PH_WAIT: begin
                in_slot = 1'b0;
                slot_cnt = 8'd0;
                if (!it.data_in || ({1'b0, wait_cnt} + 33'd1) >= {1'b0, lim}) begin
                    if (it.data_in) err_flags[1] = 1'b1;
                    bit_idx = 4'd0;
                    byte_idx = 2'd0;
                    rx_shift = 8'd0;
                    bus_phase = PH_RD_LO;
                end else begin
                    wait_cnt = wait_cnt + 32'd1;
                end
            end
            PH_RD_LO: begin
                if (slot_end) bus_phase = PH_RD_HI;
            end
            PH_RD_HI: begin
                r.sck = 1'b1;
                if (slot_end) begin
                    rx_shift = {rx_shift[6:0], it.data_in};
                    if (bit_idx >= 4'd7) begin
                        bit_idx = 4'd0;
                        bus_phase = PH_ACKR_LO;
                    end else begin
                        bit_idx = bit_idx + 4'd1;
                        bus_phase = PH_RD_LO;
                    end
                end
            end
            PH_ACKR_LO: begin
                r.data_pull_low = (byte_idx < 2'd2);
                if (slot_end) bus_phase = PH_ACKR_HI;
            end
            PH_ACKR_HI: begin
                r.sck = 1'b1;
                r.data_pull_low = (byte_idx < 2'd2);
                if (slot_end) begin
                    if (byte_idx == 2'd0) meas_word = {rx_shift, 8'h00};
                    else if (byte_idx == 2'd1) meas_word[7:0] = rx_shift;
                    else chk_byte = rx_shift;
                    if (byte_idx >= 2'd2) begin
                        bus_phase = PH_DONE;
                    end else begin
                        byte_idx = byte_idx + 2'd1;
                        rx_shift = 8'd0;
                        bus_phase = PH_RD_LO;
                    end
                end
            end
            default: begin
                r.busy_res = 1'b0;
                in_slot = 1'b0;
                slot_cnt = 8'd0;
                bus_phase = PH_IDLE;
            end
        endcase
        if (in_slot) slot_cnt = slot_end ? 8'd0 : slot_cnt + 8'd1;
    endtask

    // offer one item, with random gaps before it, and wait for its acceptance
    task automatic drive_item(input t_item it);
        while ($urandom_range(99) < gap_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        i_start_req <= it.start_req;
        i_func <= it.func;
        i_reset_first <= it.reset_first;
        i_data_in <= it.data_in;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
    endtask

    // send one tick and queue what the bus master should report for it
    task automatic bus_item(input t_item it);
        t_result r;
        logic    at_done;
        drive_item(it);
        at_done = (bus_phase == PH_DONE);
        bus_master_step(it, r);
        if (at_done && pin_known) begin
            r.measurement = pin_res.measurement;
            r.checksum = pin_res.checksum;
            r.nack_error = pin_res.nack_error;
            r.timeout_error = pin_res.timeout_error;
            pin_known = 1'b0;
        end
        bus_tick_q.push_back(r);
        items_sent++;
    endtask

    // sensor side: drive the planned level on the ticks that are sampled, noise elsewhere
    task automatic make_item(input logic want_start, output t_item it);
        logic [31:0] len;
        logic        slot_end;
        logic [7:0]  cur;
        len = (cfg_half == 8'd0) ? 32'd1 : {24'd0, cfg_half};
        slot_end = ({24'd0, slot_cnt} + 32'd1) >= len;
        it.start_req = 1'($urandom_range(1));
        it.func = 1'($urandom_range(1));
        it.reset_first = 1'($urandom_range(1));
        it.data_in = 1'($urandom_range(1));
        if (bus_phase == PH_IDLE || bus_phase == PH_DONE) begin
            it.start_req = want_start;
            if (want_start) begin
                it.func = plan_func;
                it.reset_first = plan_rst;
            end
        end else if (!plan_noise) begin
            case (bus_phase)
                PH_ACK_HI: begin
                    if (slot_end) it.data_in = plan_nack;
                end
                PH_WAIT: begin
                    if (hold_left > 0) begin
                        it.data_in = 1'b1;
                        hold_left--;
                    end else begin
                        it.data_in = 1'b0;
                    end
                end
                PH_RD_HI: begin
                    if (slot_end) begin
                        cur = plan_bytes[byte_idx];
                        it.data_in = cur[3'd7 - bit_idx[2:0]];
                    end
                end
                default: ;
            endcase
        end
    endtask

    // one measurement, either started in the done tick of the last or after idle ticks
    task automatic run_xact(input logic chain, input int idle_n);
        t_item it;
        int    k;
        if (!(chain && bus_phase == PH_DONE)) begin
            if (bus_phase == PH_DONE) begin
                make_item(1'b0, it);
                bus_item(it);
            end
            for (k = 0; k < idle_n; k++) begin
                make_item(1'b0, it);
                bus_item(it);
            end
        end
        hold_left = plan_hold;
        make_item(1'b1, it);
        bus_item(it);
        pin_known = want_known;
        pin_res = want_res;
        while (bus_phase != PH_DONE) begin
            make_item(1'b0, it);
            bus_item(it);
        end
    endtask

    // finish the pending done tick, then hold off until every result is back
    task automatic settle();
        t_item it;
        if (bus_phase == PH_DONE) begin
            make_item(1'b0, it);
            bus_item(it);
        end
        in_valid <= 1'b0;
        while (bus_tick_q.size() != 0) @(posedge i_clk);
    endtask

    // register writes, only with the block idle
    task automatic apply_config(input logic [7:0] half, input logic [31:0] limit);
        settle();
        i_cfg_we <= 1'b1;
        i_cfg_idx <= REG_HALF_PERIOD;
        i_cfg_data <= {24'd0, half};
        @(posedge i_clk);
        i_cfg_idx <= REG_TIMEOUT;
        i_cfg_data <= limit;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_half = half;
        cfg_limit = limit;
    endtask

    // mostly the shortest half period so that measurements stay quick
    task automatic rand_config();
        logic [7:0]  half;
        logic [31:0] limit;
        int          pick;
        pick = int'($urandom_range(19));
        if (pick == 0) half = 8'd0;
        else if (pick < 17) half = 8'd1;
        else half = 8'($urandom_range(3, 2));
        pick = int'($urandom_range(7));
        if (pick == 0) limit = 32'd0;
        else if (pick == 1) limit = TIMEOUT_RST;
        else if (pick == 2) limit = $urandom();
        else limit = $urandom_range(40, 1);
        apply_config(half, limit);
    endtask

    // a random measurement, now and then with a garbled data line
    task automatic rand_xact();
        plan_func = 1'($urandom_range(1));
        plan_rst = 1'($urandom_range(1));
        plan_nack = ($urandom_range(7) == 0);
        plan_noise = ($urandom_range(9) == 0);
        if (cfg_limit < 32'd48) plan_hold = int'($urandom_range(cfg_limit + 2));
        else if ($urandom_range(3) == 0) plan_hold = int'($urandom_range(40));
        else plan_hold = int'($urandom_range(3));
        plan_bytes[0] = 8'($urandom_range(255));
        plan_bytes[1] = 8'($urandom_range(255));
        plan_bytes[2] = 8'($urandom_range(255));
        want_known = 1'b0;
        run_xact($urandom_range(3) == 0, int'($urandom_range(5)));
    endtask

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fail_cnt++;
        end
    endfunction

    // result side: compare each accepted item with the oldest expectation
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && o_valid && i_ready) begin
            if (bus_tick_q.size() == 0) begin
                $error("result item with nothing expected");
                fail_cnt++;
            end else begin
                exp_r = bus_tick_q.pop_front();
                check_field("sck", 16'(exp_r.sck), 16'(o_sck));
                check_field("data_pull_low", 16'(exp_r.data_pull_low),
                            16'(o_data_pull_low));
                check_field("busy_res", 16'(exp_r.busy_res), 16'(o_busy_res));
                check_field("done_res", 16'(exp_r.done_res), 16'(o_done_res));
                check_field("nack_error", 16'(exp_r.nack_error), 16'(o_nack_error));
                check_field("timeout_error", 16'(exp_r.timeout_error),
                            16'(o_timeout_error));
                check_field("measurement", exp_r.measurement, o_measurement);
                check_field("checksum", 16'(exp_r.checksum), 16'(o_checksum));
            end
        end
        i_ready <= ($urandom_range(99) >= stall_pct);
    end

    // stimulus
    initial begin
        t_dir_row row;
        int       i;
        int       ph;
        int       base;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed measurements
        for (i = 0; i < DIR_COUNT; i++) begin
            row = DIR_ROWS[i];
            if (row.half != cfg_half || row.limit != cfg_limit)
                apply_config(row.half, row.limit);
            plan_func = row.func;
            plan_rst = row.rst_first;
            plan_nack = row.ack_hi;
            plan_noise = 1'b0;
            plan_hold = int'(row.hold);
            plan_bytes[0] = row.b0;
            plan_bytes[1] = row.b1;
            plan_bytes[2] = row.b2;
            want_known = row.known;
            want_res = '0;
            want_res.measurement = row.meas;
            want_res.checksum = row.chk;
            want_res.nack_error = row.nack;
            want_res.timeout_error = row.tmo;
            run_xact(row.chain, int'(row.idle_n));
        end

        // random measurements under three idling patterns
        for (ph = 0; ph < 3; ph++) begin
            settle();
            case (ph)
                0: begin
                    gap_pct = 19;
                    stall_pct = 57;
                end
                1: begin
                    gap_pct = 57;
                    stall_pct = 19;
                end
                default: begin
                    gap_pct = 0;
                    stall_pct = 0;
                end
            endcase
            rand_config();
            base = items_sent;
            while (items_sent - base < RAND_ITEMS) begin
                if ($urandom_range(3) == 0) rand_config();
                rand_xact();
            end
        end

        // drain and let any stray result show up
        settle();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fail_cnt == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog
    initial begin
        #WATCHDOG_NS;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
